### design/mctb_pkg.sv
// shared types and constants for the multi-channel token bucket
// no dependencies; used by the interfaces, the register block and the top level
package mctb_pkg;

    localparam int FIELD_W = 20;
    localparam int CHAN_W  = 4;
    localparam int TYPE_W  = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_TICK = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_TAKE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_GIVE = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_REFILL = 1'b0;
    localparam logic REG_BURST  = 1'b1;

    localparam logic [FIELD_W-1:0] REFILL_RESET = 20'd1024;
    localparam logic [FIELD_W-1:0] BURST_RESET  = 20'd65536;

    typedef struct packed {
        logic [FIELD_W-1:0] refill_per_tick;
        logic [FIELD_W-1:0] burst_limit;
    } cfg_t;

endpackage

### design/mctb_req_if.sv
// request channel: valid/ready handshake with request type, channel and amount
// depends on mctb_pkg
interface mctb_req_if;
    logic                          valid;
    logic                          ready;
    logic [mctb_pkg::TYPE_W-1:0]  req_type;
    logic [mctb_pkg::CHAN_W-1:0]  channel;
    logic [mctb_pkg::FIELD_W-1:0] amount;

    modport source (output valid, req_type, channel, amount, input ready);
    modport sink (input valid, req_type, channel, amount, output ready);
endinterface

### design/mctb_rsp_if.sv
// response channel: valid/ready handshake with grant, wait flag and remaining count
// depends on mctb_pkg
interface mctb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mctb_pkg::FIELD_W-1:0] granted;
    logic                          must_wait;
    logic [mctb_pkg::FIELD_W-1:0] tokens_left;

    modport source (output valid, granted, must_wait, tokens_left, input ready);
    modport sink (input valid, granted, must_wait, tokens_left, output ready);
endinterface

### design/mctb_apb_regs.sv
// apb configuration registers: refill per tick and burst limit
// depends on mctb_pkg
module mctb_apb_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mctb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mctb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mctb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    output mctb_pkg::cfg_t                    cfg
);

    logic [mctb_pkg::FIELD_W-1:0] refill_reg;
    logic [mctb_pkg::FIELD_W-1:0] burst_reg;
    logic                         wr_en;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refill_reg <= mctb_pkg::REFILL_RESET;
            burst_reg  <= mctb_pkg::BURST_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                mctb_pkg::REG_REFILL: refill_reg <= pwdata[mctb_pkg::FIELD_W-1:0];
                mctb_pkg::REG_BURST:  burst_reg  <= pwdata[mctb_pkg::FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            mctb_pkg::REG_REFILL: prdata = mctb_pkg::APB_DATA_W'(refill_reg);
            mctb_pkg::REG_BURST:  prdata = mctb_pkg::APB_DATA_W'(burst_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.refill_per_tick = refill_reg;
    assign cfg.burst_limit     = burst_reg;

endmodule

### design/multi_channel_token_bucket.sv
// take / give-back: RMW writes the count, RESP loads the output register once it is free, then idle
// tick: SWEEP updates every channel in turn, then RESP; a bad type or channel goes straight to RESP
// one request in flight at a time; the output register frees the response side
// reset clears all counts to zero through per-entry valid bits, no clearing pass
// registers reset to refill 1024 and burst limit 65536
module multi_channel_token_bucket
#(
    parameter int CHANNELS    = 16,
    parameter int COUNT_WIDTH = 20
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mctb_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mctb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mctb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                              pready,
    mctb_req_if.sink                          req,
    mctb_rsp_if.source                        rsp
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = ((COUNT_WIDTH > mctb_pkg::FIELD_W) ? COUNT_WIDTH
                                                              : mctb_pkg::FIELD_W) + 1;
    localparam int FW    = mctb_pkg::FIELD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RMW   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    mctb_pkg::cfg_t cfg;

    mctb_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // count memory and per-entry valid bits
    logic [COUNT_WIDTH-1:0] cnt_mem [CHANNELS];
    logic [CHANNELS-1:0]    valid_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_idx;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_idx;
    logic [COUNT_WIDTH-1:0] wr_data;

    logic [1:0]             state_reg, state_next;
    logic [IDX_W-1:0]       sweep_idx_reg, sweep_idx_next;
    logic                   take_reg, take_next;
    logic [IDX_W-1:0]       ch_idx_reg, ch_idx_next;
    logic [FW-1:0]          amount_reg, amount_next;

    logic [FW-1:0]          res_granted_reg, res_granted_next;
    logic                   res_wait_reg, res_wait_next;
    logic [FW-1:0]          res_left_reg, res_left_next;

    logic                   rsp_valid_reg;
    logic [FW-1:0]          rsp_granted_reg;
    logic                   rsp_wait_reg;
    logic [FW-1:0]          rsp_left_reg;
    logic                   slot_free;
    logic                   rsp_load;

    logic                   accept;
    logic [8:0]             ch_wide;
    logic                   ch_in_range;

    // datapath
    logic [COUNT_WIDTH-1:0] cnt_cur;
    logic [SUM_W-1:0]       lim_w;
    logic [SUM_W-1:0]       burst_w;
    logic [SUM_W-1:0]       cmax_w;
    logic [FW-1:0]          add_src;
    logic [SUM_W-1:0]       sum_w;
    logic [COUNT_WIDTH-1:0] clip_cnt;
    logic [SUM_W-1:0]       amt_w;
    logic [SUM_W-1:0]       cnt_w;
    logic [SUM_W-1:0]       grant_w;
    logic [COUNT_WIDTH-1:0] take_cnt;
    logic                   cnt_empty;
    logic [COUNT_WIDTH-1:0] new_cnt;

    assign req.ready   = (state_reg == ST_IDLE);
    assign accept      = req.valid && req.ready;
    assign ch_wide     = 9'(req.channel);
    assign ch_in_range = (ch_wide < 9'(CHANNELS));

    assign cnt_cur   = rd_valid_reg ? rd_data_reg : '0;
    assign burst_w   = SUM_W'(cfg.burst_limit);
    assign cmax_w    = SUM_W'({COUNT_WIDTH{1'b1}});
    assign lim_w     = (burst_w < cmax_w) ? burst_w : cmax_w;
    assign add_src   = (state_reg == ST_SWEEP) ? cfg.refill_per_tick : amount_reg;
    assign sum_w     = SUM_W'(cnt_cur) + SUM_W'(add_src);
    assign clip_cnt  = (sum_w > lim_w) ? COUNT_WIDTH'(lim_w) : COUNT_WIDTH'(sum_w);
    assign amt_w     = SUM_W'(amount_reg);
    assign cnt_w     = SUM_W'(cnt_cur);
    assign grant_w   = (amt_w < cnt_w) ? amt_w : cnt_w;
    assign take_cnt  = COUNT_WIDTH'(cnt_w - grant_w);
    assign cnt_empty = (cnt_cur == '0);
    assign new_cnt   = take_reg ? take_cnt : clip_cnt;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign rsp_load  = (state_reg == ST_RESP) && slot_free;

    always_comb
    begin
        state_next       = state_reg;
        sweep_idx_next   = sweep_idx_reg;
        take_next        = take_reg;
        ch_idx_next      = ch_idx_reg;
        amount_next      = amount_reg;
        res_granted_next = res_granted_reg;
        res_wait_next    = res_wait_reg;
        res_left_next    = res_left_reg;
        rd_en            = 1'b0;
        rd_idx           = '0;
        wr_en            = 1'b0;
        wr_idx           = ch_idx_reg;
        wr_data          = new_cnt;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    take_next        = (req.req_type == mctb_pkg::REQ_TAKE);
                    ch_idx_next      = ch_wide[IDX_W-1:0];
                    amount_next      = req.amount;
                    res_granted_next = '0;
                    res_wait_next    = 1'b0;
                    res_left_next    = '0;
                    priority if (req.req_type == mctb_pkg::REQ_TICK)
                    begin
                        rd_en          = 1'b1;
                        rd_idx         = '0;
                        sweep_idx_next = '0;
                        take_next      = 1'b0;
                        state_next     = ST_SWEEP;
                    end
                    else if ((req.req_type == mctb_pkg::REQ_TAKE ||
                              req.req_type == mctb_pkg::REQ_GIVE) && ch_in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = ch_wide[IDX_W-1:0];
                        state_next = ST_RMW;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RMW:
            begin
                wr_en            = 1'b1;
                wr_idx           = ch_idx_reg;
                wr_data          = new_cnt;
                res_granted_next = take_reg ? FW'(grant_w) : '0;
                res_wait_next    = take_reg && cnt_empty;
                res_left_next    = FW'(SUM_W'(new_cnt));
                state_next       = ST_RESP;
            end
            ST_SWEEP:
            begin
                // read of the next entry overlaps the write of this one
                wr_en   = 1'b1;
                wr_idx  = sweep_idx_reg;
                wr_data = clip_cnt;
                if (sweep_idx_reg == IDX_W'(CHANNELS - 1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_idx         = sweep_idx_reg + IDX_W'(1);
                    sweep_idx_next = sweep_idx_reg + IDX_W'(1);
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_idx_reg   <= sweep_idx_next;
        take_reg        <= take_next;
        ch_idx_reg      <= ch_idx_next;
        amount_reg      <= amount_next;
        res_granted_reg <= res_granted_next;
        res_wait_reg    <= res_wait_next;
        res_left_reg    <= res_left_next;
        if (rsp_load)
        begin
            rsp_granted_reg <= res_granted_reg;
            rsp_wait_reg    <= res_wait_reg;
            rsp_left_reg    <= res_left_reg;
        end
    end

    // count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cnt_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= cnt_mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.granted     = rsp_granted_reg;
    assign rsp.must_wait   = rsp_wait_reg;
    assign rsp.tokens_left = rsp_left_reg;

`ifndef SYNTHESIS
    a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_RMW || state_reg == ST_SWEEP))
        else $error("count memory written outside an update");

    a_rsp_from_resp_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_RESP)
        else $error("response raised without a finished request");

    a_wait_means_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_wait_reg |-> rsp_granted_reg == '0)
        else $error("grant with wait flag set");

    a_sweep_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP && $past(state_reg) == ST_IDLE |-> sweep_idx_reg == '0)
        else $error("tick sweep did not start at entry zero");

    a_no_grant_beyond_request: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RMW |=> res_granted_reg <= amount_reg)
        else $error("grant exceeds requested amount");
`endif

endmodule
